/* src/jfps_pkg.sv */
// Package for the Jacobi five-point stencil: field widths, defaults,
// register indexes and the result record type.
// No dependencies.
package jfps_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ROW_W        = 16;
  localparam int COL_W        = 11;
  localparam int ROW_CNT_W    = 17;
  localparam int MAX_COLS_DEF = 1024;
  localparam int OQ_DEPTH     = 3;

  localparam logic [ROW_W-1:0] ROW_COUNT_RST = 16'd1;
  localparam logic [COL_W-1:0] COL_COUNT_RST = 11'd1024;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_col;
    logic                       sweep_last;
  } out_t;

endpackage

/* src/jfps_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered read.
// Read during write to the same entry returns the old contents.
// No dependencies.
module jfps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* src/jfps_out_fifo.sv */
// Small result queue between the compute stage and the output channel.
// Depends on jfps_pkg (out_t, OQ_DEPTH).
module jfps_out_fifo (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  jfps_pkg::out_t                        push_data_i,
  input  logic                                  pop_i,
  output jfps_pkg::out_t                        data_o,
  output logic                                  valid_o,
  output logic [$clog2(jfps_pkg::OQ_DEPTH+1)-1:0] count_o
);

  localparam int Depth = jfps_pkg::OQ_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  jfps_pkg::out_t entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* src/jacobi_four_point_stencil.sv */
// Jacobi five-point stencil, one sweep over a raster stream of grid values.
// Depends on jfps_pkg, jfps_ram and jfps_out_fifo.
//
// Input channel (in_valid_i/in_ready_o): one Q2.14 grid value per item, in
// raster order: top halo row, row_count interior rows, bottom halo row, each
// col_count values wide. sweep_start_i on an item restarts the position
// counters at the top halo row. Items past the bottom halo row are taken and
// dropped until the next sweep start.
// Output channel (out_valid_o/out_ready_i): one item per interior point, the
// quarter sum of its four neighbors (left/right edges count as zero), with
// its row and column from one; sweep_last_o marks the final point.
// Config port: cfg_we_i writes row_count (index 0) or col_count (index 1);
// write only while the block is idle.
// Timing: one item per cycle while in_ready_o stays high. Both line rows sit
// in one RAM entry per column; a dual read port fetches the point's own
// column and its right neighbor in the cycle of acceptance. A result passes
// through the compute stage registers and the result queue before it appears.
// Reset clears counters and restores register defaults; line RAM contents
// are left as they are. When the receiver stalls, a three-entry result
// queue absorbs in-flight results; in_ready_o drops when they and queued ones fill it.
module jacobi_four_point_stencil #(
  parameter int MAX_COLS = jfps_pkg::MAX_COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  input  logic               sweep_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] average_o,
  output logic [15:0]        out_row_o,
  output logic [10:0]        out_col_o,
  output logic               sweep_last_o
);

  localparam int AddrW   = $clog2(MAX_COLS);
  localparam int CntW    = $clog2(MAX_COLS + 1);
  localparam int ColW    = jfps_pkg::COL_W;
  localparam int RowW    = jfps_pkg::ROW_W;
  localparam int SmpW    = jfps_pkg::SAMPLE_W;
  localparam int RcW     = jfps_pkg::ROW_CNT_W;
  localparam int CmpW    = (CntW > ColW) ? CntW : ColW;
  localparam int OqCntW  = $clog2(jfps_pkg::OQ_DEPTH + 1);
  localparam int SumW    = SmpW + 2;
  localparam int EntW    = 2 * SmpW;

  // Configuration registers
  logic [RowW-1:0] row_count_q;
  logic [ColW-1:0] col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= jfps_pkg::ROW_COUNT_RST;
      col_count_q <= jfps_pkg::COL_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jfps_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i[RowW-1:0];
        jfps_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes
  logic [CmpW-1:0]  col_cfg_ext;
  logic [CntW-1:0]  cols;
  logic [AddrW-1:0] last_col;
  logic [RcW-1:0]   rows, rows_p1;

  assign col_cfg_ext = CmpW'(col_count_q);
  assign cols = (col_count_q == '0) ? CntW'(1) :
                (col_cfg_ext > CmpW'(MAX_COLS)) ? CntW'(MAX_COLS) : CntW'(col_cfg_ext);
  assign last_col = AddrW'(cols - CntW'(1));
  assign rows     = (row_count_q == '0) ? RcW'(1) : RcW'(row_count_q);
  assign rows_p1  = rows + RcW'(1);

  // Accept stage: position, skip decision, RAM reads
  logic [RcW-1:0]   row_cnt_q, row_cnt_d;
  logic [AddrW-1:0] col_cnt_q, col_cnt_d;
  logic [RcW-1:0]   r;
  logic [AddrW-1:0] c_raw, c;
  logic [CntW-1:0]  col_p1;
  logic             accept, skip, take, at_last_col;
  logic [OqCntW:0]  occupancy;

  logic [OqCntW-1:0] oq_count;
  logic              s1_act_q, s1_prod_q;

  assign occupancy  = {1'b0, oq_count} + (OqCntW+1)'(s1_prod_q);
  assign in_ready_o = (occupancy < (OqCntW+1)'(jfps_pkg::OQ_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign r           = sweep_start_i ? '0 : row_cnt_q;
  assign c_raw       = sweep_start_i ? '0 : col_cnt_q;
  assign c           = (c_raw > last_col) ? last_col : c_raw;
  assign skip        = (r > rows_p1);
  assign take        = accept && !skip;
  assign at_last_col = (c == last_col);
  assign col_p1      = CntW'(c) + CntW'(1);

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (take) begin
      if (at_last_col) begin
        col_cnt_d = '0;
        row_cnt_d = r + RcW'(1);
      end else begin
        col_cnt_d = c + AddrW'(1);
        row_cnt_d = r;
      end
    end
  end

  // Compute stage registers
  logic [AddrW-1:0]       s1_c_q;
  logic signed [SmpW-1:0] s1_s_q;
  logic                   s1_c0_q, s1_redge_q, s1_last_q;
  logic [RowW-1:0]        s1_row_q;
  logic [ColW-1:0]        s1_col_q;
  logic signed [SmpW-1:0] prev_mid_q;
  logic                   fwd_a_q, fwd_b_q;
  logic [EntW-1:0]        fwd_data_q;

  // RAM entry: [upper | middle]
  logic [EntW-1:0]  rdata_a, rdata_b, wdata, ent;
  logic [AddrW-1:0] raddr_b;
  logic signed [SmpW-1:0] mid, up, left, right;
  logic signed [SumW-1:0] sum;

  assign raddr_b = c + AddrW'(1);

  assign ent   = fwd_a_q ? fwd_data_q : rdata_a;
  assign mid   = ent[SmpW-1:0];
  assign up    = ent[EntW-1:SmpW];
  assign left  = s1_c0_q ? '0 : prev_mid_q;
  assign right = s1_redge_q ? '0 : (fwd_b_q ? fwd_data_q[SmpW-1:0] : rdata_b[SmpW-1:0]);
  assign sum   = {{2{up[SmpW-1]}}, up} + {{2{s1_s_q[SmpW-1]}}, s1_s_q}
               + {{2{left[SmpW-1]}}, left} + {{2{right[SmpW-1]}}, right};
  assign wdata = {mid, s1_s_q};

  jfps_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (s1_act_q),
    .waddr_i   (s1_c_q),
    .wdata_i   (wdata),
    .re_i      (take),
    .raddr_a_i (c),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      s1_act_q  <= 1'b0;
      s1_prod_q <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      s1_act_q  <= take;
      s1_prod_q <= take && (r >= RcW'(2));
    end
  end

  // Payload and forwarding: the write in flight at the read edge bypasses RAM
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_c_q     <= c;
      s1_s_q     <= sample_i;
      s1_c0_q    <= (c == '0);
      s1_redge_q <= at_last_col;
      s1_last_q  <= (r == rows_p1) && at_last_col;
      s1_row_q   <= RowW'(r - RcW'(1));
      s1_col_q   <= ColW'(col_p1);
      fwd_a_q    <= s1_act_q && (s1_c_q == c);
      fwd_b_q    <= s1_act_q && (s1_c_q == raddr_b);
      fwd_data_q <= wdata;
    end
    if (s1_act_q) begin
      prev_mid_q <= mid;
    end
  end

  // Result queue
  jfps_pkg::out_t push_data, oq_data;

  always_comb begin
    push_data.average    = sum[SumW-1:2];
    push_data.out_row    = s1_row_q;
    push_data.out_col    = s1_col_q;
    push_data.sweep_last = s1_last_q;
  end

  jfps_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_prod_q),
    .push_data_i (push_data),
    .pop_i       (out_ready_i),
    .data_o      (oq_data),
    .valid_o     (out_valid_o),
    .count_o     (oq_count)
  );

  assign average_o    = oq_data.average;
  assign out_row_o    = oq_data.out_row;
  assign out_col_o    = oq_data.out_col;
  assign sweep_last_o = oq_data.sweep_last;

  // Assertions
  a_prod_has_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_prod_q |-> s1_act_q)
    else $error("result produced without line write");

  a_start_halo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sweep_start_i) |=>
      (s1_act_q && (s1_c_q == '0) && !s1_prod_q))
    else $error("sweep start item not placed at halo row, column zero");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_prod_q |-> (oq_count < OqCntW'(jfps_pkg::OQ_DEPTH)))
    else $error("result queue full with result in flight");

  a_skip_no_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && skip) |=> ($stable(row_cnt_q) && $stable(col_cnt_q) && !s1_act_q))
    else $error("dropped item changed stream position");

endmodule
